### src/crpp_pkg.sv
// credit-pull request parser: shared types and constants
// used by every module of the parser, no dependencies
package crpp_pkg;

    localparam logic [31:0] REQ_MAGIC = 32'h5443_5251;
    localparam int unsigned HDR_BYTES = 64;
    localparam int unsigned REC_BYTES = 36;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_HDR_ONE = 2'd0,
        KIND_HDR_TWO = 2'd1,
        KIND_RECORD  = 2'd2,
        KIND_VERDICT = 2'd3
    } kind_t;

    localparam logic [3:0] VERD_OK      = 4'd0;
    localparam logic [3:0] VERD_LENGTH  = 4'd1;
    localparam logic [3:0] VERD_MAGIC   = 4'd2;
    localparam logic [3:0] VERD_FRAMING = 4'd3;
    localparam logic [3:0] VERD_RECRES  = 4'd4;
    localparam logic [3:0] VERD_HEADER  = 4'd5;
    localparam logic [3:0] VERD_SESSION = 4'd6;
    localparam logic [3:0] VERD_RESOURCE = 4'd7;
    localparam logic [3:0] VERD_USAGE   = 4'd8;

    localparam int unsigned FL_MAGIC  = 0;
    localparam int unsigned FL_FRAME  = 1;
    localparam int unsigned FL_HEADER = 2;
    localparam int unsigned FL_RECRES = 3;

    typedef struct packed {
        logic        has_res;
        kind_t       kind;
        logic [63:0] word_a;
        logic [63:0] word_b;
        logic [63:0] word_c;
        logic [63:0] word_d;
        logic [31:0] small_value;
        logic        has_verd;
        logic [3:0]  verdict;
    } entry_t;

endpackage

### src/crpp_front.sv
// front end: byte counter, field shifter, header and record checks
// emits one queue entry per byte that causes results; uses crpp_pkg
module crpp_front #(
    parameter int RESOURCE_KINDS    = 4,
    parameter int MAX_MESSAGE_BYTES = 208
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic            push,
    output crpp_pkg::entry_t push_entry
);
    import crpp_pkg::*;

    localparam int CW = $clog2(MAX_MESSAGE_BYTES + 2);

    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [5:0]                rpos_reg, rpos_next;
    logic [63:0]               shift_reg, shift_next;
    logic [63:0]               hw0_reg, hw0_next, hw1_reg, hw1_next;
    logic [63:0]               hw2_reg, hw2_next, hw3_reg, hw3_next;
    logic [31:0]               qos_reg, qos_next;
    logic [3:0]                flags_reg, flags_next;
    logic [15:0]               decl_reg, decl_next;
    logic [63:0]               rf0_reg, rf0_next, rf1_reg, rf1_next, rf2_reg, rf2_next;
    logic [15:0]               rid_reg, rid_next;
    logic [RESOURCE_KINDS-1:0] seen_reg, seen_next;
    logic [3:0]                rerr_reg, rerr_next;

    logic [63:0]               f;
    logic [RESOURCE_KINDS-1:0] seen_sh;
    logic [64:0]               usage_sum;
    logic [22:0]               expect_len;
    logic [3:0]                verd;
    logic                      zs;

    always_comb begin
        cnt_next   = cnt_reg;
        rpos_next  = rpos_reg;
        shift_next = shift_reg;
        hw0_next   = hw0_reg;
        hw1_next   = hw1_reg;
        hw2_next   = hw2_reg;
        hw3_next   = hw3_reg;
        qos_next   = qos_reg;
        flags_next = flags_reg;
        decl_next  = decl_reg;
        rf0_next   = rf0_reg;
        rf1_next   = rf1_reg;
        rf2_next   = rf2_reg;
        rid_next   = rid_reg;
        seen_next  = seen_reg;
        rerr_next  = rerr_reg;
        push       = 1'b0;
        push_entry = '0;
        f          = {shift_reg[55:0], in_byte};
        seen_sh    = RESOURCE_KINDS'(seen_reg >> (rid_reg - 16'd1));
        usage_sum  = {1'b0, rf0_reg} + {1'b0, f};

        if (in_accept && cnt_reg < CW'(MAX_MESSAGE_BYTES)) begin
            shift_next = f;
            if (cnt_reg < CW'(HDR_BYTES)) begin
                case (cnt_reg[5:0])
                    6'd3:  if (f[31:0] != REQ_MAGIC) flags_next[FL_MAGIC] = 1'b1;
                    6'd5:  if (f[15:0] != 16'd1) flags_next[FL_HEADER] = 1'b1;
                    6'd7:  if (f[15:0] != 16'd0) flags_next[FL_HEADER] = 1'b1;
                    6'd15: begin
                        hw0_next = f;
                        if (f == 64'd0) flags_next[FL_HEADER] = 1'b1;
                    end
                    6'd19: qos_next = f[31:0];
                    6'd27: hw1_next = f;
                    6'd35: hw2_next = f;
                    6'd43: begin
                        hw3_next = f;
                        push = 1'b1;
                        push_entry.has_res = 1'b1;
                        push_entry.kind = KIND_HDR_ONE;
                        push_entry.word_a = hw0_reg;
                        push_entry.word_b = hw1_reg;
                        push_entry.word_c = hw2_reg;
                        push_entry.word_d = f;
                        push_entry.small_value = qos_reg;
                    end
                    6'd51: begin
                        hw0_next = f;
                        if (f == 64'd0) flags_next[FL_HEADER] = 1'b1;
                    end
                    6'd59: rf0_next = f;
                    6'd61: decl_next = f[15:0];
                    6'd63: begin
                        if (f[15:0] != 16'd0) flags_next[FL_FRAME] = 1'b1;
                        push = 1'b1;
                        push_entry.has_res = 1'b1;
                        push_entry.kind = KIND_HDR_TWO;
                        push_entry.word_a = hw0_reg;
                        push_entry.word_b = rf0_reg;
                        push_entry.small_value = {16'd0, decl_reg};
                    end
                    default: ;
                endcase
            end else begin
                rpos_next = (rpos_reg == 6'(REC_BYTES - 1)) ? 6'd0 : rpos_reg + 6'd1;
                case (rpos_reg)
                    6'd1:  rid_next = f[15:0];
                    6'd3:  if (f[15:0] != 16'd0) flags_next[FL_RECRES] = 1'b1;
                    6'd11: rf0_next = f;
                    6'd19: rf1_next = f;
                    6'd27: rf2_next = f;
                    6'd35: begin
                        if (rerr_reg == VERD_OK) begin
                            if (rid_reg < 16'd1 || rid_reg > 16'(RESOURCE_KINDS) ||
                                seen_sh[0]) begin
                                rerr_next = VERD_RESOURCE;
                            end else begin
                                seen_next = seen_reg |
                                    RESOURCE_KINDS'({{(RESOURCE_KINDS-1){1'b0}}, 1'b1}
                                        << (rid_reg - 16'd1));
                                if (rf1_reg > rf0_reg || rf2_reg > f || usage_sum[64])
                                    rerr_next = VERD_USAGE;
                            end
                        end
                        push = 1'b1;
                        push_entry.has_res = 1'b1;
                        push_entry.kind = KIND_RECORD;
                        push_entry.word_a = rf0_reg;
                        push_entry.word_b = rf1_reg;
                        push_entry.word_c = rf2_reg;
                        push_entry.word_d = f;
                        push_entry.small_value = {16'd0, rid_reg};
                    end
                    default: ;
                endcase
            end
        end
        if (in_accept && cnt_reg <= CW'(MAX_MESSAGE_BYTES))
            cnt_next = cnt_reg + CW'(1);

        expect_len = 23'(HDR_BYTES) + 23'(decl_next) * 23'(REC_BYTES);
        zs = (hw1_next == 64'd0) && (hw2_next == 64'd0);
        if (cnt_next < CW'(HDR_BYTES) || cnt_next > CW'(MAX_MESSAGE_BYTES))
            verd = VERD_LENGTH;
        else if (flags_next[FL_MAGIC])
            verd = VERD_MAGIC;
        else if (flags_next[FL_FRAME] || decl_next == 16'd0 ||
                 decl_next > 16'(RESOURCE_KINDS) || 23'(cnt_next) != expect_len)
            verd = VERD_FRAMING;
        else if (flags_next[FL_RECRES])
            verd = VERD_RECRES;
        else if (flags_next[FL_HEADER])
            verd = VERD_HEADER;
        else if (zs != (hw3_next == 64'd0))
            verd = VERD_SESSION;
        else
            verd = rerr_next;

        if (in_accept && in_last) begin
            push = 1'b1;
            push_entry.has_verd = 1'b1;
            push_entry.verdict = verd;
            cnt_next   = '0;
            rpos_next  = '0;
            shift_next = '0;
            hw0_next   = '0;
            hw1_next   = '0;
            hw2_next   = '0;
            hw3_next   = '0;
            qos_next   = '0;
            flags_next = '0;
            decl_next  = '0;
            rf0_next   = '0;
            rf1_next   = '0;
            rf2_next   = '0;
            rid_next   = '0;
            seen_next  = '0;
            rerr_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            rpos_reg  <= '0;
            shift_reg <= '0;
            hw0_reg   <= '0;
            hw1_reg   <= '0;
            hw2_reg   <= '0;
            hw3_reg   <= '0;
            qos_reg   <= '0;
            flags_reg <= '0;
            decl_reg  <= '0;
            rf0_reg   <= '0;
            rf1_reg   <= '0;
            rf2_reg   <= '0;
            rid_reg   <= '0;
            seen_reg  <= '0;
            rerr_reg  <= '0;
        end else begin
            cnt_reg   <= cnt_next;
            rpos_reg  <= rpos_next;
            shift_reg <= shift_next;
            hw0_reg   <= hw0_next;
            hw1_reg   <= hw1_next;
            hw2_reg   <= hw2_next;
            hw3_reg   <= hw3_next;
            qos_reg   <= qos_next;
            flags_reg <= flags_next;
            decl_reg  <= decl_next;
            rf0_reg   <= rf0_next;
            rf1_reg   <= rf1_next;
            rf2_reg   <= rf2_next;
            rid_reg   <= rid_next;
            seen_reg  <= seen_next;
            rerr_reg  <= rerr_next;
        end
    end

endmodule

### src/crpp_queue.sv
// short entry queue between front end and back end
// register array with read and write pointers; uses crpp_pkg
module crpp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  crpp_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             q_valid,
    output crpp_pkg::entry_t head
);
    import crpp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    entry_t          mem [QUEUE_DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     count_reg;

    assign full    = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push)
            mem[wptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push)
                wptr_reg <= wptr_reg + AW'(1);
            if (pop)
                rptr_reg <= rptr_reg + AW'(1);
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

### src/crpp_back.sv
// back end: expands queue entries into result transfers
// owns the output register; uses crpp_pkg
module crpp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  crpp_pkg::entry_t head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [295:0]     m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    import crpp_pkg::*;

    logic         valid_reg;
    logic         phase_reg;
    logic [295:0] data_reg;
    logic [1:0]   user_reg;
    logic         last_reg;
    logic         load;
    logic         send_res;

    assign load     = !valid_reg || m_tready;
    assign send_res = head.has_res && !phase_reg;
    assign pop      = load && q_valid && !(send_res && head.has_verd);

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (load && q_valid) begin
            if (send_res) begin
                data_reg <= {4'd0, VERD_OK, head.small_value, head.word_d,
                             head.word_c, head.word_b, head.word_a};
                user_reg <= head.kind;
                last_reg <= !head.has_verd;
            end else begin
                data_reg <= {4'd0, head.verdict, 288'd0};
                user_reg <= KIND_VERDICT;
                last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= q_valid;
            if (q_valid)
                phase_reg <= send_res && head.has_verd;
        end
    end

    a_verdict_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_VERDICT) |-> m_tlast)
        else $error("verdict transfer without tlast");

    a_data_no_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_VERDICT) |-> (m_tdata[291:288] == VERD_OK))
        else $error("nonzero verdict on data transfer");

    a_phase_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> q_valid)
        else $error("verdict phase with empty queue");

endmodule

### src/credit_pull_request_parser_core.sv
// credit-pull request parser, top level
// joins crpp_front, crpp_queue and crpp_back; uses crpp_pkg
//
// input channel s_*: one message byte per transfer, tlast on the final byte
// of a message. result channel m_*: tuser is the result kind (header part
// one, header part two, resource record, verdict), tlast marks the last
// result caused by one input byte.
// a byte is taken every cycle while the four-entry queue between front end
// and back end has room; the front end parses and checks a byte in the cycle
// it is accepted. a result passes through the queue and the output register
// on its way to m_*. a byte causing a record or header result and the verdict
// yields two transfers, other bytes at most one; unstalled, one byte per cycle.
// reset clears all parse state, the queue and the output register; each
// verdict also returns the parse state to reset for the next message.
// a stalled receiver holds the output register, the queue fills and
// s_tready drops once it is full.
module credit_pull_request_parser_core #(
    parameter int RESOURCE_KINDS    = 4,
    parameter int MAX_MESSAGE_BYTES = 208
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // in_byte
    input  logic         s_tlast,   // end_of_message
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [295:0] m_tdata,   // word_a, word_b, word_c, word_d, small_value, verdict
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast    // run_last
);
    import crpp_pkg::*;

    logic   in_accept;
    logic   push, pop, full, q_valid;
    entry_t push_entry, head;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    crpp_front #(
        .RESOURCE_KINDS   (RESOURCE_KINDS),
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .push_entry(push_entry)
    );

    crpp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .full      (full),
        .q_valid   (q_valid),
        .head      (head)
    );

    crpp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

### tb/credit_pull_request_parser_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for credit_pull_request_parser_core
// builds request messages byte by byte and checks results against a local predictor
// depends on crpp_pkg and the parser rtl
module credit_pull_request_parser_core_tb;
    import crpp_pkg::*;

    localparam int KINDS     = 4;
    localparam int MAX_BYTES = 208;
    localparam int LIMIT     = 400000;

    typedef struct {
        kind_t       kind;
        logic [63:0] wa, wb, wc, wd;
        logic [31:0] sv;
        logic [3:0]  verd;
        logic        last;
    } parse_result_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = 0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [295:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    credit_pull_request_parser_core dut (.*);

    always #4 aclk = ~aclk;

    logic [8:0]    pending_bytes[$];
    logic [7:0]    msg[$];
    parse_result_t expected_results[$];
    int            phase = 0;
    int            send_idle = 0, recv_stall = 0;
    int            hold_cnt = 0;
    bit            hold_done = 0;
    bit            taken = 0;
    int            errors = 0, cycles = 0, bytes_in = 0, results_out = 0, messages = 0;
    int            verdict_seen[9];

    // predictor state
    logic [7:0]  p_count;
    logic [63:0] p_shift;
    logic [63:0] p_held[4];
    logic [31:0] p_qos;
    logic [3:0]  p_flags;
    logic [15:0] p_declared;
    logic [63:0] p_rec[4];
    logic [15:0] p_id;
    logic [3:0]  p_seen;
    logic [3:0]  p_rec_err;

    function automatic void parser_clear();
        p_count = 0; p_shift = 0; p_qos = 0; p_flags = 0; p_declared = 0;
        p_id = 0; p_seen = 0; p_rec_err = VERD_OK;
        for (int i = 0; i < 4; i++) begin
            p_held[i] = 0;
            p_rec[i] = 0;
        end
    endfunction

    function automatic void add_expected(kind_t k, logic [63:0] a, b, c, d,
                                         logic [31:0] s, logic [3:0] v);
        parse_result_t r;
        r.kind = k; r.wa = a; r.wb = b; r.wc = c; r.wd = d; r.sv = s; r.verd = v;
        r.last = 0;
        expected_results = {expected_results, r};
    endfunction

    function automatic void queue_byte(logic [8:0] v);
        pending_bytes = {pending_bytes, v};
    endfunction

    function automatic void msg_add(logic [7:0] v);
        msg = {msg, v};
    endfunction

    function automatic logic [3:0] message_verdict();
        int  len;
        bit  zs;
        len = p_count;
        if (len < HDR_BYTES || len > MAX_BYTES) return VERD_LENGTH;
        if (p_flags[FL_MAGIC]) return VERD_MAGIC;
        if (p_flags[FL_FRAME] || p_declared == 0 || p_declared > KINDS ||
            len != HDR_BYTES + p_declared * REC_BYTES) return VERD_FRAMING;
        if (p_flags[FL_RECRES]) return VERD_RECRES;
        if (p_flags[FL_HEADER]) return VERD_HEADER;
        zs = (p_held[1] == 0) && (p_held[2] == 0);
        if (zs != (p_held[3] == 0)) return VERD_SESSION;
        return p_rec_err;
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic eom);
        int          p, q, n0;
        logic [63:0] f, cons, comp, mn, ds;
        n0 = expected_results.size();
        p = p_count;
        if (p < MAX_BYTES) begin
            p_shift = {p_shift[55:0], b};
            f = p_shift;
            if (p < HDR_BYTES) begin
                case (p)
                    3:  if (f[31:0] != REQ_MAGIC) p_flags[FL_MAGIC] = 1;
                    5:  if (f[15:0] != 1) p_flags[FL_HEADER] = 1;
                    7:  if (f[15:0] != 0) p_flags[FL_HEADER] = 1;
                    15: begin
                        p_held[0] = f;
                        if (f == 0) p_flags[FL_HEADER] = 1;
                    end
                    19: p_qos = f[31:0];
                    27: p_held[1] = f;
                    35: p_held[2] = f;
                    43: begin
                        p_held[3] = f;
                        add_expected(KIND_HDR_ONE, p_held[0], p_held[1], p_held[2],
                                     p_held[3], p_qos, VERD_OK);
                    end
                    51: begin
                        p_held[0] = f;
                        if (f == 0) p_flags[FL_HEADER] = 1;
                    end
                    59: p_rec[0] = f;
                    61: p_declared = f[15:0];
                    63: begin
                        if (f[15:0] != 0) p_flags[FL_FRAME] = 1;
                        add_expected(KIND_HDR_TWO, p_held[0], p_rec[0], 0, 0,
                                     {16'd0, p_declared}, VERD_OK);
                    end
                    default: ;
                endcase
            end else begin
                q = (p - HDR_BYTES) % REC_BYTES;
                case (q)
                    1:  p_id = f[15:0];
                    3:  if (f[15:0] != 0) p_flags[FL_RECRES] = 1;
                    11: p_rec[0] = f;
                    19: p_rec[1] = f;
                    27: p_rec[2] = f;
                    35: begin
                        cons = p_rec[0]; comp = p_rec[1]; mn = p_rec[2]; ds = f;
                        p_rec[3] = f;
                        if (p_rec_err == VERD_OK) begin
                            if (p_id < 1 || p_id > KINDS || p_seen[p_id - 1]) begin
                                p_rec_err = VERD_RESOURCE;
                            end else begin
                                p_seen[p_id - 1] = 1;
                                if (comp > cons || mn > ds || ds > ~cons)
                                    p_rec_err = VERD_USAGE;
                            end
                        end
                        add_expected(KIND_RECORD, cons, comp, mn, ds, {16'd0, p_id},
                                     VERD_OK);
                    end
                    default: ;
                endcase
            end
        end
        if (p_count <= MAX_BYTES) p_count++;
        if (eom) begin
            add_expected(KIND_VERDICT, 0, 0, 0, 0, 0, message_verdict());
            verdict_seen[expected_results[$].verd]++;
            parser_clear();
        end
        if (expected_results.size() > n0) expected_results[$].last = 1;
    endfunction

    // input side and checking, both on the rising edge
    always @(posedge aclk) begin
        parse_result_t e;
        cycles <= cycles + 1;
        taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            parse_byte(s_tdata, s_tlast);
            bytes_in <= bytes_in + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_out <= results_out + 1;
            if (expected_results.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10) $display("unexpected result kind %0d", m_tuser);
            end else begin
                e = expected_results.pop_front();
                if (m_tuser != e.kind || m_tdata[63:0] != e.wa ||
                    m_tdata[127:64] != e.wb || m_tdata[191:128] != e.wc ||
                    m_tdata[255:192] != e.wd || m_tdata[287:256] != e.sv ||
                    m_tdata[291:288] != e.verd || m_tlast != e.last) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: exp kind %0d a %h b %h c %h d %h s %h v %0d l %0d\n          got kind %0d a %h b %h c %h d %h s %h v %0d l %0d",
                                 e.kind, e.wa, e.wb, e.wc, e.wd, e.sv, e.verd, e.last,
                                 m_tuser, m_tdata[63:0], m_tdata[127:64],
                                 m_tdata[191:128], m_tdata[255:192],
                                 m_tdata[287:256], m_tdata[291:288], m_tlast);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // byte driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || taken)) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
                {s_tlast, s_tdata} <= pending_bytes.pop_front();
                s_tvalid <= 1;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // long receiver hold-off while bytes keep coming
    always @(negedge aclk) begin
        if (phase == 2 && !hold_done) begin
            hold_cnt <= 300;
            hold_done <= 1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && hold_cnt == 0 && $urandom_range(99) >= recv_stall;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic put_be(logic [63:0] v, int nb);
        for (int i = nb - 1; i >= 0; i--) msg_add(v[i*8 +: 8]);
    endtask

    task automatic queue_msg();
        for (int i = 0; i < msg.size(); i++)
            queue_byte({(i == msg.size() - 1) ? 1'b1 : 1'b0, msg[i]});
        messages++;
    endtask

    // well-formed request with random content, then at most one defect
    task automatic build_request();
        logic [31:0] magic;
        logic [15:0] schema, flags, count, hres;
        logic [63:0] peer, shi, slo, epoch, reqseq, lastupd;
        logic [31:0] qos;
        logic [15:0] ids[4], rres[4];
        logic [63:0] cons[4], comp[4], mn[4], ds[4];
        int          n, defect, r, k, t;
        msg.delete();
        magic = REQ_MAGIC; schema = 1; flags = 0; hres = 0;
        peer = rand64() | 64'd1; qos = $urandom; reqseq = rand64() | 64'd1;
        lastupd = rand64();
        if ($urandom_range(3) == 0) begin
            shi = 0; slo = 0; epoch = 0;
        end else begin
            shi = rand64(); slo = rand64(); epoch = rand64() | 64'd1;
        end
        n = $urandom_range(KINDS, 1);
        count = 16'(n);
        for (int i = 0; i < 4; i++) ids[i] = 16'(i + 1);
        for (int i = 3; i > 0; i--) begin
            k = $urandom_range(i);
            {ids[i], ids[k]} = {ids[k], ids[i]};
        end
        for (int i = 0; i < 4; i++) begin
            rres[i] = 0;
            cons[i] = rand64();
            comp[i] = cons[i] & rand64();
            ds[i] = ~cons[i] & rand64();
            mn[i] = ds[i] & rand64();
        end
        defect = ($urandom_range(99) < 40) ? 0 : $urandom_range(12, 1);
        r = $urandom_range(n - 1);
        case (defect)
            3: magic[$urandom_range(31)] ^= 1;
            4: count = ($urandom_range(1)) ? 16'($urandom_range(7)) : 16'($urandom);
            5: rres[r] = 16'($urandom_range(65535, 1));
            6: case ($urandom_range(3))
                   0: schema = 16'($urandom_range(65535, 2));
                   1: flags = 16'($urandom_range(65535, 1));
                   2: peer = 0;
                   default: reqseq = 0;
               endcase
            7: if (epoch == 0) epoch = rand64() | 64'd1; else epoch = 0;
            8: ids[r] = ($urandom_range(1)) ? 16'd0 :
                        16'($urandom_range(65535, KINDS + 1));
            9: if (n > 1) ids[1] = ids[0]; else ids[0] = 0;
            10: case ($urandom_range(2))
                    0: if (cons[r] != 0) comp[r] = cons[r] + 1 + ($urandom & 64'hff);
                       else comp[r] = 1;
                    1: mn[r] = (ds[r] == 64'hffff_ffff_ffff_ffff) ? 64'hffff_ffff_ffff_ffff :
                               ds[r] + 1;
                    default: if (cons[r] != 0) ds[r] = ~cons[r] + 1; else ds[r] = 0;
                endcase
            11: hres = 16'($urandom_range(65535, 1));
            default: ;
        endcase
        put_be(magic, 4); put_be(schema, 2); put_be(flags, 2); put_be(peer, 8);
        put_be(qos, 4); put_be(shi, 8); put_be(slo, 8); put_be(epoch, 8);
        put_be(reqseq, 8); put_be(lastupd, 8); put_be(count, 2); put_be(hres, 2);
        for (int i = 0; i < n; i++) begin
            put_be(ids[i], 2); put_be(rres[i], 2); put_be(cons[i], 8);
            put_be(comp[i], 8); put_be(mn[i], 8); put_be(ds[i], 8);
        end
        case (defect)
            1: begin
                t = $urandom_range(msg.size() - 1, 1);
                while (msg.size() > t) void'(msg.pop_back());
            end
            2: begin
                t = $urandom_range(MAX_BYTES + 12, msg.size() + 1);
                while (msg.size() < t) msg_add(8'($urandom));
            end
            12: begin
                t = $urandom_range(40, 1);
                for (int i = 0; i < t; i++) msg_add(8'($urandom));
            end
            default: ;
        endcase
        queue_msg();
    endtask

    task automatic wait_drained();
        wait (pending_bytes.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int target;
        parser_clear();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        // directed: lone bytes and very short messages
        queue_byte({1'b1, 8'h00});
        queue_byte({1'b1, 8'hff});
        queue_byte({1'b0, 8'h54});
        queue_byte({1'b0, 8'h43});
        queue_byte({1'b1, 8'h52});
        queue_byte({1'b0, 8'haa});
        queue_byte({1'b1, 8'h55});
        messages += 4;
        wait_drained();
        for (int ph = 0; ph < 4; ph++) begin
            phase = ph;
            send_idle  = (ph == 1) ? 60 : (ph == 3) ? 13 : 0;
            recv_stall = (ph == 2) ? 60 : (ph == 3) ? 13 : 0;
            target = bytes_in + ((ph == 2) ? 150 : 1);
            while (bytes_in + pending_bytes.size() < target) begin
                build_request();
                if (pending_bytes.size() > 300) wait (pending_bytes.size() < 100);
            end
            wait_drained();
        end
        send_idle = 0; recv_stall = 0;
        repeat (20) @(posedge aclk);
        $display("sent %0d bytes in %0d messages, checked %0d results", bytes_in,
                 messages, results_out);
        $display("verdicts ok %0d len %0d magic %0d frame %0d rres %0d hdr %0d sess %0d res %0d use %0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
                 verdict_seen[4], verdict_seen[5], verdict_seen[6], verdict_seen[7],
                 verdict_seen[8]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", errors,
                     expected_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### files.f
src/crpp_pkg.sv
src/crpp_front.sv
src/crpp_queue.sv
src/crpp_back.sv
src/credit_pull_request_parser_core.sv
tb/credit_pull_request_parser_core_tb.sv
